// ===== hdl/idbc_pkg.sv =====
// Shared types and constants for the infusion dose BCD controller.
package idbc_pkg;

	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned VOLUME_W = 23;
	localparam int unsigned DRAIN_W  = 14;
	localparam int unsigned CAP_W    = 10;
	localparam int unsigned ID_W     = 8;
	localparam int unsigned CODE_W   = 10;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;

	typedef logic [DIGIT_W-1:0] digit_t;
	// index 0 is tens, 1 units, 2 tenths, 3 hundredths
	typedef digit_t [3:0] dose_t;

	localparam logic [1:0] CMD_REQUEST = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_REFILL  = 2'd2;

	localparam logic [CODE_W-1:0] CODE_INCREASE = 10'd100;
	localparam logic [CODE_W-1:0] CODE_DECREASE = 10'd200;
	localparam logic [CODE_W-1:0] CODE_STOP     = 10'd300;

	localparam logic [1:0] ACK_REJECT   = 2'd0;
	localparam logic [1:0] ACK_INCREASE = 2'd1;
	localparam logic [1:0] ACK_DECREASE = 2'd2;
	localparam logic [1:0] ACK_STOP     = 2'd3;

	localparam logic REG_OWN_ID   = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	localparam digit_t               TOP_DIGIT     = 4'd9;
	localparam logic [VOLUME_W-1:0]  UNITS_PER_ML  = 23'd6000;
	localparam logic [VOLUME_W-1:0]  RESET_VOLUME  = 23'd360000;
	localparam logic [ID_W-1:0]      RESET_OWN_ID  = 8'd1;
	localparam logic [CAP_W-1:0]     RESET_CAP_ML  = 10'd60;

	typedef struct packed {
		logic capture;
		logic apply;
		logic load_count;
		logic step;
		logic next_pos;
		logic publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic change;
		logic count_zero;
		logic pos_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hdl/infusion_dose_bcd_controller.sv =====
// Top level of the syringe-pump dose controller: APB registers, controller, datapath.
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+----------------------------------------
//  config   | psel/penable/pwrite, pready=1     | paddr[2:0], pwdata, prdata
//  request  | in_valid / in_ready               | command, request_code, target_id, step_*
//  result   | out_valid / out_ready             | responded, ack_code, dose_*, remaining,
//           |                                   | empty_res
//
//  A tick, refill, stop or rejected request passes the class state, where it is applied,
//  and the finish state. Increase and decrease go through the count state: one digit
//  step per cycle through the shared BCD stepper, and a move to the next digit place.
//  One request is in work at a time; a result waiting in the output register
//  does not block the next accept, only its own publish.
//  arst_n clears the dose, sets the volume to 360000 and the registers to 1 and 60.
module infusion_dose_bcd_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [idbc_pkg::APB_AW-1:0]        paddr,
	input  logic [idbc_pkg::APB_DW-1:0]        pwdata,
	output logic [idbc_pkg::APB_DW-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         command,
	input  logic [idbc_pkg::CODE_W-1:0]        request_code,
	input  logic [idbc_pkg::ID_W-1:0]          target_id,
	input  logic [idbc_pkg::DIGIT_W-1:0]       step_tens,
	input  logic [idbc_pkg::DIGIT_W-1:0]       step_units,
	input  logic [idbc_pkg::DIGIT_W-1:0]       step_tenths,
	input  logic [idbc_pkg::DIGIT_W-1:0]       step_hundredths,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               responded,
	output logic [1:0]                         ack_code,
	output logic [idbc_pkg::DIGIT_W-1:0]       dose_tens,
	output logic [idbc_pkg::DIGIT_W-1:0]       dose_units,
	output logic [idbc_pkg::DIGIT_W-1:0]       dose_tenths,
	output logic [idbc_pkg::DIGIT_W-1:0]       dose_hundredths,
	output logic [idbc_pkg::VOLUME_W-1:0]      remaining,
	output logic                               empty_res
);

	logic [idbc_pkg::ID_W-1:0]  own_id;
	logic [idbc_pkg::CAP_W-1:0] capacity_ml;
	idbc_pkg::ctrl_cmd_t        cmd;
	idbc_pkg::dp_status_t       st;

	idbc_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.own_id      (own_id),
		.capacity_ml (capacity_ml)
	);

	idbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	idbc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.own_id          (own_id),
		.capacity_ml     (capacity_ml),
		.command         (command),
		.request_code    (request_code),
		.target_id       (target_id),
		.step_tens       (step_tens),
		.step_units      (step_units),
		.step_tenths     (step_tenths),
		.step_hundredths (step_hundredths),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.responded       (responded),
		.ack_code        (ack_code),
		.dose_tens       (dose_tens),
		.dose_units      (dose_units),
		.dose_tenths     (dose_tenths),
		.dose_hundredths (dose_hundredths),
		.remaining       (remaining),
		.empty_res       (empty_res)
	);

endmodule

// ===== hdl/idbc_regs.sv =====
// APB configuration registers: pump identifier and syringe capacity.
module idbc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [idbc_pkg::APB_AW-1:0]      paddr,
	input  logic [idbc_pkg::APB_DW-1:0]      pwdata,
	output logic [idbc_pkg::APB_DW-1:0]      prdata,
	output logic                             pready,
	output logic [idbc_pkg::ID_W-1:0]        own_id,
	output logic [idbc_pkg::CAP_W-1:0]       capacity_ml
);

	logic [idbc_pkg::ID_W-1:0]  own_id_q;
	logic [idbc_pkg::CAP_W-1:0] capacity_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q   <= idbc_pkg::RESET_OWN_ID;
			capacity_q <= idbc_pkg::RESET_CAP_ML;
		end else if (wr_en) begin
			case (paddr[2])
				idbc_pkg::REG_OWN_ID:   own_id_q   <= pwdata[idbc_pkg::ID_W-1:0];
				idbc_pkg::REG_CAPACITY: capacity_q <= pwdata[idbc_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			idbc_pkg::REG_OWN_ID:
				prdata = {{(idbc_pkg::APB_DW-idbc_pkg::ID_W){1'b0}}, own_id_q};
			idbc_pkg::REG_CAPACITY:
				prdata = {{(idbc_pkg::APB_DW-idbc_pkg::CAP_W){1'b0}}, capacity_q};
			default:
				prdata = '0;
		endcase
	end

	assign own_id      = own_id_q;
	assign capacity_ml = capacity_q;

endmodule

// ===== hdl/idbc_dp.sv =====
// Datapath: request capture, BCD dose stepper, volume drain and result register.
module idbc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  idbc_pkg::ctrl_cmd_t                cmd,
	output idbc_pkg::dp_status_t               st,
	input  logic [idbc_pkg::ID_W-1:0]          own_id,
	input  logic [idbc_pkg::CAP_W-1:0]         capacity_ml,
	input  logic [1:0]                         command,
	input  logic [idbc_pkg::CODE_W-1:0]        request_code,
	input  logic [idbc_pkg::ID_W-1:0]          target_id,
	input  logic [idbc_pkg::DIGIT_W-1:0]       step_tens,
	input  logic [idbc_pkg::DIGIT_W-1:0]       step_units,
	input  logic [idbc_pkg::DIGIT_W-1:0]       step_tenths,
	input  logic [idbc_pkg::DIGIT_W-1:0]       step_hundredths,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               responded,
	output logic [1:0]                         ack_code,
	output logic [idbc_pkg::DIGIT_W-1:0]       dose_tens,
	output logic [idbc_pkg::DIGIT_W-1:0]       dose_units,
	output logic [idbc_pkg::DIGIT_W-1:0]       dose_tenths,
	output logic [idbc_pkg::DIGIT_W-1:0]       dose_hundredths,
	output logic [idbc_pkg::VOLUME_W-1:0]      remaining,
	output logic                               empty_res
);

	// one single-digit step at pos, carry or borrow toward tens
	function automatic idbc_pkg::dose_t step_dose(input idbc_pkg::dose_t d,
		input logic [1:0] pos, input logic up);
		idbc_pkg::dose_t r;
		logic            carry;
		r     = d;
		carry = 1'b1;
		for (int i = 3; i >= 2; i--) begin
			if (carry && (2'(i) <= pos)) begin
				if (up) begin
					if (r[i] < idbc_pkg::TOP_DIGIT) begin
						r[i]  = r[i] + 4'd1;
						carry = 1'b0;
					end else begin
						r[i] = '0;
					end
				end else begin
					if (r[i] != '0) begin
						r[i]  = r[i] - 4'd1;
						carry = 1'b0;
					end else begin
						r[i] = idbc_pkg::TOP_DIGIT;
					end
				end
			end
		end
		if (carry && pos != 2'd0) begin
			if (up) begin
				if (r[1] < idbc_pkg::TOP_DIGIT) begin
					r[1] = r[1] + 4'd1;
				end else if (r[0] < idbc_pkg::TOP_DIGIT) begin
					r[0] = r[0] + 4'd1;
					r[1] = '0;
				end
			end else begin
				if (r[1] != '0) begin
					r[1] = r[1] - 4'd1;
				end else if (r[0] != '0) begin
					r[0] = r[0] - 4'd1;
					r[1] = idbc_pkg::TOP_DIGIT;
				end
			end
			carry = 1'b0;
		end
		if (carry) begin
			if (up) begin
				if (r[0] < idbc_pkg::TOP_DIGIT) r[0] = r[0] + 4'd1;
			end else begin
				if (r[0] != '0) r[0] = r[0] - 4'd1;
			end
		end
		return r;
	endfunction

	logic [1:0]                      cmd_q;
	logic [idbc_pkg::CODE_W-1:0]     code_q;
	logic [idbc_pkg::ID_W-1:0]       target_q;
	idbc_pkg::dose_t                 steps_q;
	idbc_pkg::dose_t                 dose_q;
	logic [idbc_pkg::VOLUME_W-1:0]   vol_q;
	logic                            empty_q;
	logic [idbc_pkg::DIGIT_W-1:0]    count_q;
	logic [1:0]                      pos_q;
	logic                            out_valid_q;

	logic                            ours;
	logic                            is_up;
	logic [idbc_pkg::DRAIN_W-1:0]    drain;
	logic [idbc_pkg::VOLUME_W-1:0]   full_vol;
	logic [1:0]                      ack_d;
	logic [1:0]                      pos_dec;

	assign ours  = (cmd_q == idbc_pkg::CMD_REQUEST) && (target_q == own_id);
	assign is_up = (code_q == idbc_pkg::CODE_INCREASE);

	assign drain = idbc_pkg::DRAIN_W'(dose_q[0]) * 14'd1000
		+ idbc_pkg::DRAIN_W'(dose_q[1]) * 14'd100
		+ idbc_pkg::DRAIN_W'(dose_q[2]) * 14'd10
		+ idbc_pkg::DRAIN_W'(dose_q[3]);
	assign full_vol = idbc_pkg::VOLUME_W'(capacity_ml) * idbc_pkg::UNITS_PER_ML;
	assign pos_dec  = pos_q - 2'd1;

	always_comb begin
		ack_d = idbc_pkg::ACK_REJECT;
		if (ours) begin
			case (code_q)
				idbc_pkg::CODE_INCREASE: ack_d = idbc_pkg::ACK_INCREASE;
				idbc_pkg::CODE_DECREASE: ack_d = idbc_pkg::ACK_DECREASE;
				idbc_pkg::CODE_STOP:     ack_d = idbc_pkg::ACK_STOP;
				default:                 ack_d = idbc_pkg::ACK_REJECT;
			endcase
		end
	end

	assign st.change     = ours && (is_up || code_q == idbc_pkg::CODE_DECREASE);
	assign st.count_zero = (count_q == '0);
	assign st.pos_zero   = (pos_q == 2'd0);
	assign st.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q      <= command;
			code_q     <= request_code;
			target_q   <= target_id;
			steps_q[0] <= step_tens;
			steps_q[1] <= step_units;
			steps_q[2] <= step_tenths;
			steps_q[3] <= step_hundredths;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dose_q  <= '0;
			vol_q   <= idbc_pkg::RESET_VOLUME;
			empty_q <= 1'b0;
			count_q <= '0;
			pos_q   <= 2'd3;
		end else begin
			if (cmd.capture) pos_q <= 2'd3;
			if (cmd.load_count) count_q <= steps_q[pos_q];
			if (cmd.next_pos) begin
				pos_q   <= pos_dec;
				count_q <= steps_q[pos_dec];
			end
			if (cmd.step) begin
				dose_q  <= step_dose(dose_q, pos_q, is_up);
				count_q <= count_q - 4'd1;
			end
			if (cmd.apply) begin
				case (cmd_q)
					idbc_pkg::CMD_REQUEST: begin
						if (ours && code_q == idbc_pkg::CODE_STOP) dose_q <= '0;
					end
					idbc_pkg::CMD_TICK: begin
						if (!empty_q) begin
							if (idbc_pkg::VOLUME_W'(drain) >= vol_q) begin
								vol_q   <= '0;
								empty_q <= 1'b1;
							end else begin
								vol_q <= vol_q - idbc_pkg::VOLUME_W'(drain);
							end
						end
					end
					idbc_pkg::CMD_REFILL: begin
						vol_q   <= full_vol;
						empty_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			responded       <= ours;
			ack_code        <= ack_d;
			dose_tens       <= dose_q[0];
			dose_units      <= dose_q[1];
			dose_tenths     <= dose_q[2];
			dose_hundredths <= dose_q[3];
			remaining       <= vol_q;
			empty_res       <= empty_q;
		end
	end

	assign out_valid = out_valid_q;

	a_empty_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (vol_q == '0))
		else $error("empty flag set with volume left");

	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		(dose_q[0] <= idbc_pkg::TOP_DIGIT) && (dose_q[1] <= idbc_pkg::TOP_DIGIT)
		&& (dose_q[2] <= idbc_pkg::TOP_DIGIT) && (dose_q[3] <= idbc_pkg::TOP_DIGIT))
		else $error("dose digit above nine");

	a_valid_from_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.publish))
		else $error("result valid without publish");

endmodule

// ===== hdl/idbc_ctrl.sv =====
// Controller: sequences capture, digit steps, state update and result publish.
module idbc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  idbc_pkg::dp_status_t  st,
	output idbc_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CLASS  = 4'b0010,
		ST_COUNT  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CLASS;
				end
			end
			ST_CLASS: begin
				if (st.change) begin
					cmd.load_count = 1'b1;
					state_d        = ST_COUNT;
				end else begin
					cmd.apply = 1'b1;
					state_d   = ST_FINISH;
				end
			end
			ST_COUNT: begin
				if (!st.count_zero) begin
					cmd.step = 1'b1;
				end else if (!st.pos_zero) begin
					cmd.next_pos = 1'b1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (st.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_publish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> st.out_free)
		else $error("publish into occupied result register");

	a_step_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !st.count_zero)
		else $error("digit step with zero count");

	a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("request taken while another is in work");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the infusion dose BCD controller.
`timescale 1ns / 100ps

import idbc_pkg::*;

typedef struct {
	logic [1:0]        command;
	logic [CODE_W-1:0] code;
	logic [ID_W-1:0]   target;
	dose_t             steps;
} pump_request_t;

typedef struct {
	logic                responded;
	logic [1:0]          ack;
	dose_t               dose;
	logic [VOLUME_W-1:0] volume;
	logic                empty;
} pump_report_t;

class dose_ledger;
	logic [ID_W-1:0]     own_id;
	logic [CAP_W-1:0]    cap_ml;
	dose_t               dose;
	logic [VOLUME_W-1:0] volume;
	logic                empty;
	pump_report_t        expected_reports[$];
	int                  mismatches;

	function new();
		own_id     = RESET_OWN_ID;
		cap_ml     = RESET_CAP_ML;
		dose       = '0;
		volume     = RESET_VOLUME;
		empty      = 1'b0;
		mismatches = 0;
	endfunction

	function void set_register(logic idx, logic [APB_DW-1:0] value);
		if (idx == REG_OWN_ID) begin
			own_id = value[ID_W-1:0];
		end else begin
			cap_ml = value[CAP_W-1:0];
		end
	endfunction

	function int pending();
		return expected_reports.size();
	endfunction

	// carry runs from the given place toward tens; tens and units hold at the top
	function void bump_up(int pos);
		while (pos > 1) begin
			if (dose[pos] < TOP_DIGIT) begin
				dose[pos] = dose[pos] + 1'b1;
				return;
			end
			dose[pos] = '0;
			pos--;
		end
		if (pos == 1) begin
			if (dose[1] < TOP_DIGIT) begin
				dose[1] = dose[1] + 1'b1;
			end else if (dose[0] < TOP_DIGIT) begin
				dose[0] = dose[0] + 1'b1;
				dose[1] = '0;
			end
		end else if (dose[0] < TOP_DIGIT) begin
			dose[0] = dose[0] + 1'b1;
		end
	endfunction

	function void bump_down(int pos);
		while (pos > 1) begin
			if (dose[pos] > 0) begin
				dose[pos] = dose[pos] - 1'b1;
				return;
			end
			dose[pos] = TOP_DIGIT;
			pos--;
		end
		if (pos == 1) begin
			if (dose[1] > 0) begin
				dose[1] = dose[1] - 1'b1;
			end else if (dose[0] > 0) begin
				dose[0] = dose[0] - 1'b1;
				dose[1] = TOP_DIGIT;
			end
		end else if (dose[0] > 0) begin
			dose[0] = dose[0] - 1'b1;
		end
	endfunction

	function void change_dose(dose_t steps, bit up);
		for (int pos = 3; pos >= 0; pos--) begin
			for (int k = 0; k < steps[pos]; k++) begin
				if (up) begin
					bump_up(pos);
				end else begin
					bump_down(pos);
				end
			end
		end
	endfunction

	function void note_request(pump_request_t req);
		pump_report_t want;
		int drain;
		want.responded = 1'b0;
		want.ack       = ACK_REJECT;
		case (req.command)
			CMD_REQUEST: begin
				if (req.target == own_id) begin
					want.responded = 1'b1;
					if (req.code == CODE_INCREASE) begin
						change_dose(req.steps, 1'b1);
						want.ack = ACK_INCREASE;
					end else if (req.code == CODE_DECREASE) begin
						change_dose(req.steps, 1'b0);
						want.ack = ACK_DECREASE;
					end else if (req.code == CODE_STOP) begin
						dose     = '0;
						want.ack = ACK_STOP;
					end
				end
			end
			CMD_TICK: begin
				if (!empty) begin
					drain = 1000 * dose[0] + 100 * dose[1] + 10 * dose[2] + dose[3];
					if (drain >= volume) begin
						volume = '0;
						empty  = 1'b1;
					end else begin
						volume = volume - VOLUME_W'(drain);
					end
				end
			end
			CMD_REFILL: begin
				volume = VOLUME_W'(int'(cap_ml) * int'(UNITS_PER_ML));
				empty  = 1'b0;
			end
			default: ;
		endcase
		want.dose   = dose;
		want.volume = volume;
		want.empty  = empty;
		expected_reports.push_back(want);
	endfunction

	function void flag(string what, logic [31:0] want, logic [31:0] seen);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, seen);
		end
	endfunction

	function void check_result(pump_report_t seen);
		pump_report_t want;
		if (expected_reports.size() == 0) begin
			flag("unexpected result, responded", 0, seen.responded);
			return;
		end
		want = expected_reports.pop_front();
		if (seen.responded !== want.responded) flag("responded", want.responded, seen.responded);
		if (seen.ack !== want.ack) flag("ack_code", want.ack, seen.ack);
		if (seen.dose[0] !== want.dose[0]) flag("dose_tens", want.dose[0], seen.dose[0]);
		if (seen.dose[1] !== want.dose[1]) flag("dose_units", want.dose[1], seen.dose[1]);
		if (seen.dose[2] !== want.dose[2]) flag("dose_tenths", want.dose[2], seen.dose[2]);
		if (seen.dose[3] !== want.dose[3]) flag("dose_hundredths", want.dose[3], seen.dose[3]);
		if (seen.volume !== want.volume) flag("remaining", want.volume, seen.volume);
		if (seen.empty !== want.empty) flag("empty_res", want.empty, seen.empty);
	endfunction
endclass

module tb;

	localparam logic [1:0] CMD_IGNORED     = 2'd3;
	localparam int         ITEMS_PER_PHASE = 207;
	localparam int         QUIET_LIMIT     = 2000;
	localparam int         SETTLE_CYCLES   = 80;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata, prdata;
	logic                pready;
	logic                in_valid, in_ready;
	logic [1:0]          command;
	logic [CODE_W-1:0]   request_code;
	logic [ID_W-1:0]     target_id;
	digit_t              step_tens, step_units, step_tenths, step_hundredths;
	logic                out_valid, out_ready;
	logic                responded;
	logic [1:0]          ack_code;
	digit_t              dose_tens, dose_units, dose_tenths, dose_hundredths;
	logic [VOLUME_W-1:0] remaining;
	logic                empty_res;

	dose_ledger ledger;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         quiet_cycles;

	infusion_dose_bcd_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .request_code(request_code), .target_id(target_id),
		.step_tens(step_tens), .step_units(step_units),
		.step_tenths(step_tenths), .step_hundredths(step_hundredths),
		.out_valid(out_valid), .out_ready(out_ready),
		.responded(responded), .ack_code(ack_code),
		.dose_tens(dose_tens), .dose_units(dose_units),
		.dose_tenths(dose_tenths), .dose_hundredths(dose_hundredths),
		.remaining(remaining), .empty_res(empty_res)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		pump_report_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.responded = responded;
			seen.ack       = ack_code;
			seen.dose[0]   = dose_tens;
			seen.dose[1]   = dose_units;
			seen.dose[2]   = dose_tenths;
			seen.dose[3]   = dose_hundredths;
			seen.volume    = remaining;
			seen.empty     = empty_res;
			ledger.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
			$display("[infusion_dose_bcd_controller] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic pump_request_t make_request(logic [1:0] cmd, logic [CODE_W-1:0] code,
			logic [ID_W-1:0] tgt, digit_t t, digit_t u, digit_t te, digit_t h);
		pump_request_t req;
		req.command  = cmd;
		req.code     = code;
		req.target   = tgt;
		req.steps[0] = t;
		req.steps[1] = u;
		req.steps[2] = te;
		req.steps[3] = h;
		return req;
	endfunction

	function automatic pump_request_t random_request();
		pump_request_t req;
		int            pick;
		int            top;
		req.command = CMD_REQUEST;
		req.code    = CODE_W'($urandom_range(1023));
		req.target  = ID_W'($urandom_range(255));
		top         = ($urandom_range(7) == 0) ? 15 : 9;
		for (int pos = 0; pos < 4; pos++) begin
			req.steps[pos] = digit_t'($urandom_range(top));
		end
		pick = $urandom_range(99);
		if (pick < 45) begin
			if ($urandom_range(9) < 8) begin
				req.target = ledger.own_id;
			end
			pick = $urandom_range(9);
			if (pick < 4) begin
				req.code = CODE_INCREASE;
			end else if (pick < 8) begin
				req.code = CODE_DECREASE;
			end else if (pick == 8) begin
				req.code = CODE_STOP;
			end
		end else if (pick < 75) begin
			req.command = CMD_TICK;
		end else if (pick < 88) begin
			req.command = CMD_REFILL;
		end else if (pick < 93) begin
			req.command = CMD_IGNORED;
		end
		return req;
	endfunction

	// entered and left just after a falling edge
	task automatic send_request(pump_request_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		command         <= req.command;
		request_code    <= req.code;
		target_id       <= req.target;
		step_tens       <= req.steps[0];
		step_units      <= req.steps[1];
		step_tenths     <= req.steps[2];
		step_hundredths <= req.steps[3];
		do @(posedge clk); while (!in_ready);
		ledger.note_request(req);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (ledger.pending() != 0) @(negedge clk);
	endtask

	task automatic write_register(logic idx, logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.set_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(logic [ID_W-1:0] id, logic [CAP_W-1:0] cap, int idle_pct,
			int stall_pct, bit hold_mid);
		pump_request_t req;
		int            sent;
		drain_results();
		write_register(REG_OWN_ID, APB_DW'(id));
		write_register(REG_CAPACITY, APB_DW'(cap));
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent           = 0;
		while (sent < ITEMS_PER_PHASE) begin
			req = random_request();
			send_request(req);
			if (req.command != CMD_IGNORED) begin
				sent++;
			end
			if (hold_mid && sent == ITEMS_PER_PHASE / 2) begin
				hold_mid = 1'b0;
				drain_results();
			end
		end
	endtask

	initial begin
		ledger          = new();
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_valid        = 1'b0;
		command         = CMD_REQUEST;
		request_code    = '0;
		target_id       = '0;
		step_tens       = '0;
		step_units      = '0;
		step_tenths     = '0;
		step_hundredths = '0;
		out_ready       = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		quiet_cycles    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: own id 1, 60 ml
		send_request(make_request(CMD_TICK, '0, '0, 0, 0, 0, 0));
		send_request(make_request(CMD_REQUEST, CODE_INCREASE, 8'd1, 9, 9, 9, 9));
		send_request(make_request(CMD_REQUEST, CODE_INCREASE, 8'd1, 0, 0, 0, 1));
		send_request(make_request(CMD_TICK, '1, '1, 15, 15, 15, 15));
		send_request(make_request(CMD_REQUEST, CODE_DECREASE, 8'd1, 15, 15, 15, 15));
		send_request(make_request(CMD_REQUEST, CODE_STOP, 8'd1, 0, 0, 0, 0));
		send_request(make_request(CMD_REQUEST, CODE_DECREASE, 8'd1, 0, 0, 0, 1));
		send_request(make_request(CMD_REQUEST, CODE_INCREASE, 8'd1, 15, 15, 15, 15));
		send_request(make_request(CMD_REQUEST, '0, 8'd1, 1, 1, 1, 1));
		send_request(make_request(CMD_REQUEST, '1, 8'd1, 1, 1, 1, 1));
		send_request(make_request(CMD_REQUEST, CODE_INCREASE, 8'd0, 1, 1, 1, 1));
		send_request(make_request(CMD_REQUEST, CODE_STOP, 8'd255, 0, 0, 0, 0));
		send_request(make_request(CMD_IGNORED, CODE_STOP, 8'd1, 0, 0, 0, 0));
		send_request(make_request(CMD_REFILL, '0, '0, 0, 0, 0, 0));

		// one-millilitre syringe: exact drain to empty, tick while empty, refill
		drain_results();
		write_register(REG_CAPACITY, APB_DW'(1));
		send_request(make_request(CMD_REQUEST, CODE_STOP, 8'd1, 0, 0, 0, 0));
		send_request(make_request(CMD_REQUEST, CODE_INCREASE, 8'd1, 6, 0, 0, 0));
		send_request(make_request(CMD_REFILL, '0, '0, 0, 0, 0, 0));
		send_request(make_request(CMD_TICK, '0, '0, 0, 0, 0, 0));
		send_request(make_request(CMD_TICK, '0, '0, 0, 0, 0, 0));
		send_request(make_request(CMD_REFILL, '0, '0, 0, 0, 0, 0));
		send_request(make_request(CMD_REQUEST, CODE_DECREASE, 8'd1, 0, 0, 0, 1));
		send_request(make_request(CMD_TICK, '0, '0, 0, 0, 0, 0));
		send_request(make_request(CMD_TICK, '0, '0, 0, 0, 0, 0));

		run_phase(8'd0, 10'd1, 0, 0, 1'b0);
		run_phase(8'd255, 10'd999, 72, 0, 1'b1);
		run_phase(ID_W'($urandom_range(255)), CAP_W'($urandom_range(999, 1)), 0, 72, 1'b0);
		run_phase(ID_W'($urandom_range(255)), 10'd3, 27, 27, 1'b0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending() == 0) begin
			$display("[infusion_dose_bcd_controller] OK");
		end else begin
			$display("[infusion_dose_bcd_controller] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/idbc_pkg.sv
hdl/idbc_regs.sv
hdl/idbc_dp.sv
hdl/idbc_ctrl.sv
hdl/infusion_dose_bcd_controller.sv
tb/tb.sv
